[sv/tensor_element_to_fp32_converter_core_assert.svh]
// Assertion macros for the converter RTL.
`ifndef TENSOR_ELEMENT_TO_FP32_CONVERTER_CORE_ASSERT_SVH
`define TENSOR_ELEMENT_TO_FP32_CONVERTER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tec_pkg.sv]
package tec_pkg;
	localparam logic [3:0] DT_F32  = 4'd0;
	localparam logic [3:0] DT_F16  = 4'd1;
	localparam logic [3:0] DT_BF16 = 4'd2;
	localparam logic [3:0] DT_F64  = 4'd3;
	localparam logic [3:0] DT_I8   = 4'd4;
	localparam logic [3:0] DT_U8   = 4'd5;
	localparam logic [3:0] DT_I16  = 4'd6;
	localparam logic [3:0] DT_I32  = 4'd7;
	localparam logic [3:0] DT_I64  = 4'd8;

	localparam logic [31:0] INF32 = 32'h7F80_0000;

	// result kind carried from front stage
	localparam logic [1:0] K_DIRECT = 2'd0; // result already final
	localparam logic [1:0] K_INT    = 2'd1; // normalize magnitude
	localparam logic [1:0] K_DBL    = 2'd2; // round double

	typedef struct packed {
		logic        last;
		logic        bad;
		logic [1:0]  kind;
		logic        sign;
		logic [31:0] direct;
		logic [63:0] mag;      // int magnitude or double mantissa (53 bits)
		logic [10:0] dexp;     // double exponent
	} front_t;

	typedef struct packed {
		logic        last;
		logic        bad;
		logic [1:0]  kind;
		logic        sign;
		logic [31:0] direct;
		logic [63:0] shifted;  // value shifted; bit 0 sticky-or
		logic [8:0]  expf;     // biased exponent field base
		logic        zero;
	} mid_t;
endpackage

[sv/tec_front.sv]
// Stage 1: decode type, direct formats, integer magnitude, double unpack.
module tec_front (
	input  logic [3:0]          dtype,
	input  logic [63:0]         elem,
	input  logic                last,
	output tec_pkg::front_t     f
);
	logic [63:0] sv;
	logic [63:0] neg;
	logic        sg;
	logic [4:0]  hex;
	logic [9:0]  hm;
	logic [3:0]  lz;
	logic [9:0]  nm;

	always_comb begin
		f = '0;
		f.last = last;
		f.kind = tec_pkg::K_DIRECT;
		sv = '0;
		sg = 1'b0;
		neg = '0;
		hex = elem[14:10];
		hm = elem[9:0];
		lz = 4'd0;
		nm = '0;
		case (dtype)
			tec_pkg::DT_F32: f.direct = elem[31:0];
			tec_pkg::DT_BF16: f.direct = {elem[15:0], 16'd0};
			tec_pkg::DT_F16: begin
				if (hex == 5'h1F)
					f.direct = {elem[15], 8'hFF, hm, 13'd0};
				else if (hex != 5'd0)
					f.direct = {elem[15], 8'(hex) + 8'd112, hm, 13'd0};
				else if (hm == 10'd0)
					f.direct = {elem[15], 31'd0};
				else begin
					for (int i = 0; i < 10; i++)
						if (hm[i]) lz = 4'(9 - i);
					nm = hm << (lz + 4'd1);
					f.direct = {elem[15], 8'd112 - 8'(lz), nm, 13'd0};
				end
			end
			tec_pkg::DT_F64: begin
				f.sign = elem[63];
				f.dexp = elem[62:52];
				if (elem[62:52] == 11'h7FF) begin
					if (elem[51:0] == 52'd0)
						f.direct = {elem[63], 31'h7F80_0000};
					else
						f.direct = {elem[63], 31'h7FC0_0000 | {9'd0, elem[50:29]}};
				end else if (elem[62:52] == 11'd0)
					f.direct = {elem[63], 31'd0};
				else begin
					f.kind = tec_pkg::K_DBL;
					f.mag = {11'd0, 1'b1, elem[51:0]};
				end
			end
			tec_pkg::DT_I8, tec_pkg::DT_U8, tec_pkg::DT_I16,
			tec_pkg::DT_I32, tec_pkg::DT_I64: begin
				f.kind = tec_pkg::K_INT;
				case (dtype)
					tec_pkg::DT_I8:  begin sg = elem[7];  sv = {{56{elem[7]}}, elem[7:0]}; end
					tec_pkg::DT_U8:  begin sg = 1'b0;     sv = {56'd0, elem[7:0]}; end
					tec_pkg::DT_I16: begin sg = elem[15]; sv = {{48{elem[15]}}, elem[15:0]}; end
					tec_pkg::DT_I32: begin sg = elem[31]; sv = {{32{elem[31]}}, elem[31:0]}; end
					default:         begin sg = elem[63]; sv = elem; end
				endcase
				neg = 64'd0 - sv;
				f.sign = sg;
				f.mag = sg ? neg : sv;
			end
			default: f.bad = 1'b1;
		endcase
	end
endmodule

[sv/tec_align.sv]
// Stage 2: leading-one search for integers, alignment shift with sticky.
module tec_align (
	input  tec_pkg::front_t f,
	output tec_pkg::mid_t   m
);
	logic [5:0]  p;
	logic [6:0]  sh;
	logic [63:0] kept;
	logic        st;
	logic [11:0] be;

	always_comb begin
		m = '0;
		m.last = f.last;
		m.bad = f.bad;
		m.kind = f.kind;
		m.sign = f.sign;
		m.direct = f.direct;
		p = '0;
		sh = '0;
		kept = '0;
		st = 1'b0;
		be = '0;
		if (f.kind == tec_pkg::K_INT) begin
			for (int i = 0; i < 64; i++)
				if (f.mag[i]) p = 6'(i);
			m.zero = (f.mag == 64'd0);
			// left-justify to bit 63, keep 24 bits + guard, sticky below
			kept = f.mag << (6'd63 - p);
			st = |kept[37:0];
			m.shifted = {kept[63:38], 37'd0, st};
			m.expf = 9'(p) + 9'd126;
		end else if (f.kind == tec_pkg::K_DBL) begin
			be = 12'(f.dexp) - 12'd896;
			if (!be[11] && be != 12'd0) begin
				sh = 7'd29;
				m.expf = be[8:0] - 9'd1;
				if (be >= 12'd255) m.zero = 1'b1;
			end else begin
				// subnormal result: denormalizing shift; far below the range it saturates and the result flushes to zero
				sh = ((12'd0 - be) > 12'd40) ? 7'd127 : 7'd30 + 7'(12'd0 - be);
				m.expf = 9'd0;
			end
			if (sh > 7'd62) begin
				kept = '0;
				st = 1'b1;
			end else begin
				kept = f.mag >> (sh - 7'd1);
				st = |(f.mag & ((64'd1 << (sh - 7'd1)) - 64'd1));
			end
			m.shifted = {kept[62:0], st};
		end
	end
endmodule

[sv/tec_round.sv]
// Stage 3: round to nearest even and pack; direct results pass through, unsupported types give zero.
module tec_round (
	input  tec_pkg::mid_t m,
	output logic [31:0]   res
);
	logic [24:0] q;
	logic        g, s, up;
	logic [31:0] bits;

	always_comb begin
		q = '0; g = 1'b0; s = 1'b0; up = 1'b0; bits = '0;
		if (m.bad)
			res = '0;
		else if (m.kind == tec_pkg::K_INT) begin
			q = {1'b0, m.shifted[63:40]};
			g = m.shifted[39];
			s = m.shifted[38] | m.shifted[0];
			up = g & (s | q[0]);
			bits = {1'b0, m.expf[7:0], 23'd0} + 32'(q + 25'(up));
			res = m.zero ? 32'd0 : {m.sign, 31'd0} | bits;
		end else if (m.kind == tec_pkg::K_DBL) begin
			// shifted: value >> (sh-1) at [63:1], sticky at [0]
			q = {1'b0, m.shifted[25:2]};
			g = m.shifted[1];
			s = m.shifted[0];
			up = g & (s | q[0]);
			bits = {1'b0, m.expf[7:0], 23'd0} + 32'(q + 25'(up));
			if (m.zero || bits >= tec_pkg::INF32) bits = tec_pkg::INF32;
			res = {m.sign, bits[30:0]};
		end else
			res = m.direct;
	end
endmodule

[sv/tensor_element_to_fp32_converter_core.sv]
// Pipeline: front, align and round, registered into f_s1, m_s2 and d_s3 in that order before the output.
// Throughput: one transfer per cycle; the three-stage pipeline holds under
// output backpressure and advances whenever the output slot frees.
// Reset: arst_n asynchronously clears the valid bits and sets dtype_q to f32.
`include "tensor_element_to_fp32_converter_core_assert.svh"
module tensor_element_to_fp32_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // element_bits[63:0]
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // float_bits[31:0]
	output logic        m_tuser,   // unsupported
	output logic        m_tlast    // last_out
);
	logic [3:0] dtype_q;
	tec_pkg::front_t f_c, f_s1;
	tec_pkg::mid_t   m_c, m_s2;
	logic [31:0]     r_c;
	logic v_s1, v_s2, v_s3;
	logic [31:0] d_s3;
	logic u_s3, l_s3;
	logic adv3, adv2, adv1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dtype_q <= tec_pkg::DT_F32;
		else if (cfg_we) dtype_q <= cfg_wdata;
	end

	// each stage advances when its own slot is empty or the stage after it advances
	assign adv3 = !v_s3 || m_tready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	tec_front u_front (.dtype(dtype_q), .elem(s_tdata), .last(s_tlast), .f(f_c));
	tec_align u_align (.f(f_s1), .m(m_c));
	tec_round u_round (.m(m_s2), .res(r_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) f_s1 <= f_c;
		if (adv2 && v_s1) m_s2 <= m_c;
		if (adv3 && v_s2) begin
			d_s3 <= r_c;
			u_s3 <= m_s2.bad;
			l_s3 <= m_s2.last;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata = d_s3;
	assign m_tuser = u_s3;
	assign m_tlast = l_s3;

	`TEC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output dropped")
	`TEC_ASSERT_IMP(a_ready, clk, arst_n, !m_tvalid, s_tready, "stall while output empty")
	`TEC_ASSERT_IMP(a_bad_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 32'd0, "bad not zero")
	`TEC_ASSERT_NEXT(a_fill, clk, arst_n, v_s2 && !v_s3, v_s3, "stage 3 not filled")
endmodule
